// File: hdl/ias_pkg.sv
// Package for the ingress arrival statistics block.
// Holds header constants, register map, and the stage structs.
// No dependencies.
package ias_pkg;

    localparam logic [16:0] ETH_HDR_BYTES   = 17'd14;
    localparam logic [16:0] IPV4_HDR_BYTES  = 17'd20;
    localparam logic [16:0] TCP_HDR_BYTES   = 17'd20;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [31:0] GAP_THRESH_RST  = 32'd1000000;
    localparam logic [31:0] GATEWAY_RST     = 32'd0;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    typedef enum logic {
        REG_GATEWAY   = 1'b0,
        REG_THRESHOLD = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] gateway_address;
        logic [31:0] gap_threshold;
    } cfg_t;

    typedef struct packed {
        logic [15:0] frame_bytes;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_header_words;
        logic [31:0] tcp_sequence;
        logic [63:0] arrival_time_ns;
    } frame_t;

    // classify stage result
    typedef struct packed {
        logic        counted;
        logic        sampled;
        logic        jump;
        logic [63:0] interval;
    } cls_t;

    // square stage result; square mod 2^64 = sq_low + (sq_cross << 33)
    typedef struct packed {
        logic        counted;
        logic        sampled;
        logic        jump;
        logic [63:0] interval;
        logic [63:0] sq_low;
        logic [30:0] sq_cross;
    } sq_t;

endpackage

// File: hdl/ias_regs.sv
// APB-style configuration registers: gateway address and gap threshold.
// Depends on ias_pkg.
module ias_regs
    import ias_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_GATEWAY:   cfg_next.gateway_address = pwdata;
                REG_THRESHOLD: cfg_next.gap_threshold   = pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_GATEWAY:   prdata = cfg_reg.gateway_address;
            REG_THRESHOLD: prdata = cfg_reg.gap_threshold;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gateway_address <= GATEWAY_RST;
            cfg_reg.gap_threshold   <= GAP_THRESH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/ias_classify.sv
// Input register and classify stage: frame checks, interval, sequence jump.
// Keeps previous arrival and sequence. Depends on ias_pkg.
module ias_classify
    import ias_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  frame_t      s_frame,
    input  logic [31:0] gap_threshold,
    output logic        out_valid,
    input  logic        out_ready,
    output cls_t        out_cls
);

    logic        in_valid_reg, in_valid_next;
    frame_t      frame_reg;
    logic        cls_valid_reg, cls_valid_next;
    cls_t        cls_reg;
    logic [63:0] prev_arrival_reg, prev_arrival_next;
    logic [31:0] prev_seq_reg, prev_seq_next;

    logic        cls_ready;
    logic        cls_load;
    logic        s_take;
    logic        is_ipv4;
    logic        is_tcp;
    logic [16:0] len_ext;
    logic [16:0] tcp_need;
    logic [31:0] seq_back;
    cls_t        cls_calc;

    assign cls_ready = !cls_valid_reg || out_ready;
    assign cls_load  = in_valid_reg && cls_ready;
    assign s_ready   = !in_valid_reg || cls_ready;
    assign s_take    = s_valid && s_ready;
    assign out_valid = cls_valid_reg;
    assign out_cls   = cls_reg;

    assign len_ext  = {1'b0, frame_reg.frame_bytes};
    assign tcp_need = ETH_HDR_BYTES + TCP_HDR_BYTES + {11'd0, frame_reg.ip_header_words, 2'b00};
    assign seq_back = prev_seq_reg - frame_reg.tcp_sequence;

    assign is_ipv4 = (frame_reg.ether_type == ETHERTYPE_IPV4)
                     && (len_ext >= ETH_HDR_BYTES + IPV4_HDR_BYTES);
    assign is_tcp  = is_ipv4 && (frame_reg.ip_protocol == PROTO_TCP) && (len_ext >= tcp_need);

    always_comb begin
        cls_calc.counted  = is_ipv4;
        cls_calc.sampled  = is_ipv4 && (prev_arrival_reg != 64'd0);
        cls_calc.interval = frame_reg.arrival_time_ns - prev_arrival_reg;
        cls_calc.jump     = is_tcp && (prev_seq_reg != 32'd0)
                            && (frame_reg.tcp_sequence < prev_seq_reg)
                            && (seq_back > gap_threshold);
    end

    always_comb begin
        prev_arrival_next = prev_arrival_reg;
        prev_seq_next     = prev_seq_reg;
        if (cls_load && is_ipv4) begin
            prev_arrival_next = frame_reg.arrival_time_ns;
        end
        if (cls_load && is_tcp) begin
            prev_seq_next = frame_reg.tcp_sequence;
        end
    end

    always_comb begin
        priority if (s_take) begin
            in_valid_next = 1'b1;
        end else if (cls_load) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        priority if (cls_load) begin
            cls_valid_next = 1'b1;
        end else if (out_ready) begin
            cls_valid_next = 1'b0;
        end else begin
            cls_valid_next = cls_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            cls_valid_reg    <= 1'b0;
            prev_arrival_reg <= 64'd0;
            prev_seq_reg     <= 32'd0;
        end else begin
            in_valid_reg     <= in_valid_next;
            cls_valid_reg    <= cls_valid_next;
            prev_arrival_reg <= prev_arrival_next;
            prev_seq_reg     <= prev_seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            frame_reg <= s_frame;
        end
        if (cls_load) begin
            cls_reg <= cls_calc;
        end
    end

endmodule

// File: hdl/ias_square.sv
// Square stage: interval squared modulo 2^64 from a low and a cross partial product.
// Depends on ias_pkg.
module ias_square
    import ias_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cls_t in_cls,
    output logic out_valid,
    input  logic out_ready,
    output sq_t  out_sq
);

    logic        sq_valid_reg, sq_valid_next;
    sq_t         sq_reg;
    sq_t         sq_calc;
    logic        sq_load;
    logic [31:0] lo;
    logic [30:0] hi;

    assign in_ready  = !sq_valid_reg || out_ready;
    assign sq_load   = in_valid && in_ready;
    assign out_valid = sq_valid_reg;
    assign out_sq    = sq_reg;

    assign lo = in_cls.interval[31:0];
    assign hi = in_cls.interval[62:32];

    always_comb begin
        sq_calc.counted  = in_cls.counted;
        sq_calc.sampled  = in_cls.sampled;
        sq_calc.jump     = in_cls.jump;
        sq_calc.interval = in_cls.interval;
        sq_calc.sq_low   = {32'd0, lo} * {32'd0, lo};
        // only the low 31 bits of the cross term survive the shift by 33
        sq_calc.sq_cross = hi * lo[30:0];
    end

    always_comb begin
        priority if (sq_load) begin
            sq_valid_next = 1'b1;
        end else if (out_ready) begin
            sq_valid_next = 1'b0;
        end else begin
            sq_valid_next = sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else begin
            sq_valid_reg <= sq_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_load) begin
            sq_reg <= sq_calc;
        end
    end

endmodule

// File: hdl/ias_accum.sv
// Accumulate stage: running statistics, which double as the result register.
// Depends on ias_pkg.
module ias_accum
    import ias_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  sq_t         in_sq,
    input  logic [31:0] gateway_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_counted,
    output logic [31:0] m_gateway_tag,
    output logic [63:0] m_packet_total,
    output logic [63:0] m_gap_sum_ns,
    output logic [63:0] m_gap_square_sum,
    output logic [63:0] m_gap_samples,
    output logic [63:0] m_sequence_jumps
);

    logic        valid_reg, valid_next;
    logic        counted_reg;
    logic [31:0] tag_reg;
    logic [63:0] pkt_reg, pkt_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] sqsum_reg, sqsum_next;
    logic [63:0] samples_reg, samples_next;
    logic [63:0] jumps_reg, jumps_next;
    logic        load;

    assign in_ready = !valid_reg || m_ready;
    assign load     = in_valid && in_ready;

    assign m_valid          = valid_reg;
    assign m_counted        = counted_reg;
    assign m_gateway_tag    = tag_reg;
    assign m_packet_total   = pkt_reg;
    assign m_gap_sum_ns     = sum_reg;
    assign m_gap_square_sum = sqsum_reg;
    assign m_gap_samples    = samples_reg;
    assign m_sequence_jumps = jumps_reg;

    always_comb begin
        pkt_next     = pkt_reg;
        sum_next     = sum_reg;
        sqsum_next   = sqsum_reg;
        samples_next = samples_reg;
        jumps_next   = jumps_reg;
        if (load && in_sq.counted) begin
            pkt_next = pkt_reg + 64'd1;
        end
        if (load && in_sq.sampled) begin
            sum_next     = sum_reg + in_sq.interval;
            sqsum_next   = sqsum_reg + in_sq.sq_low + {in_sq.sq_cross, 33'd0};
            samples_next = samples_reg + 64'd1;
        end
        if (load && in_sq.jump) begin
            jumps_next = jumps_reg + 64'd1;
        end
    end

    always_comb begin
        priority if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            pkt_reg     <= 64'd0;
            sum_reg     <= 64'd0;
            sqsum_reg   <= 64'd0;
            samples_reg <= 64'd0;
            jumps_reg   <= 64'd0;
        end else begin
            valid_reg   <= valid_next;
            pkt_reg     <= pkt_next;
            sum_reg     <= sum_next;
            sqsum_reg   <= sqsum_next;
            samples_reg <= samples_next;
            jumps_reg   <= jumps_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            counted_reg <= in_sq.counted;
            tag_reg     <= gateway_address;
        end
    end

endmodule

// File: hdl/ingress_arrival_statistics.sv
// Ingress arrival statistics, top level.
// Path: the input register loads at request accept, then the classify, square and
// accumulate registers in order. Throughput: one request per cycle unless m_ready
// stalls it, set by the 4-register pipeline with ready passed back through all stages.
// Reset clears all valids, statistics, previous arrival and sequence; gateway
// address resets to 0 and gap threshold to 1000000.
// Depends on ias_pkg, ias_regs, ias_classify, ias_square, ias_accum.
module ingress_arrival_statistics
    import ias_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_frame_bytes,
    input  logic [15:0]       s_ether_type,
    input  logic [7:0]        s_ip_protocol,
    input  logic [3:0]        s_ip_header_words,
    input  logic [31:0]       s_tcp_sequence,
    input  logic [63:0]       s_arrival_time_ns,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_counted,
    output logic [31:0]       m_gateway_tag,
    output logic [63:0]       m_packet_total,
    output logic [63:0]       m_gap_sum_ns,
    output logic [63:0]       m_gap_square_sum,
    output logic [63:0]       m_gap_samples,
    output logic [63:0]       m_sequence_jumps
);

    cfg_t   cfg;
    frame_t s_frame;
    cls_t   cls;
    sq_t    sq;
    logic   cls_valid, cls_ready;
    logic   sq_valid, sq_ready;

    assign s_frame.frame_bytes     = s_frame_bytes;
    assign s_frame.ether_type      = s_ether_type;
    assign s_frame.ip_protocol     = s_ip_protocol;
    assign s_frame.ip_header_words = s_ip_header_words;
    assign s_frame.tcp_sequence    = s_tcp_sequence;
    assign s_frame.arrival_time_ns = s_arrival_time_ns;

    ias_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ias_classify u_classify (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame       (s_frame),
        .gap_threshold (cfg.gap_threshold),
        .out_valid     (cls_valid),
        .out_ready     (cls_ready),
        .out_cls       (cls)
    );

    ias_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_cls    (cls),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_sq    (sq)
    );

    ias_accum u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (sq_valid),
        .in_ready         (sq_ready),
        .in_sq            (sq),
        .gateway_address  (cfg.gateway_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_counted        (m_counted),
        .m_gateway_tag    (m_gateway_tag),
        .m_packet_total   (m_packet_total),
        .m_gap_sum_ns     (m_gap_sum_ns),
        .m_gap_square_sum (m_gap_square_sum),
        .m_gap_samples    (m_gap_samples),
        .m_sequence_jumps (m_sequence_jumps)
    );

endmodule
